### hdl/trf_pkg.sv
// ----------------------------------------------------------------------------
// Touch report frame parser package
// Shared types and constants for the parser, its input stage and its
// result stage.
// ----------------------------------------------------------------------------
package trf_pkg;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_TYPE,
        PH_XH,
        PH_XL,
        PH_YH,
        PH_YL,
        PH_E1,
        PH_E2,
        PH_E3,
        PH_E4
    } phase_t;

    typedef enum logic [1:0] {
        EV_PRESS,
        EV_RELEASE,
        EV_POLL_TOUCH,
        EV_POLL_NONE
    } event_kind_t;

    localparam logic [2:0] MODE_POLLED      = 3'd1;
    localparam logic [2:0] MODE_PRESS       = 3'd2;
    localparam logic [2:0] MODE_RELEASE     = 3'd3;
    localparam logic [2:0] MODE_PERIODIC    = 3'd4;
    localparam logic [2:0] MODE_PRESS_OR_RL = 3'd5;

    localparam logic [7:0] BYTE_START   = 8'hfd;
    localparam logic [7:0] BYTE_END1    = 8'hdd;
    localparam logic [7:0] BYTE_END2    = 8'hcc;
    localparam logic [7:0] BYTE_END3    = 8'hbb;
    localparam logic [7:0] BYTE_END4    = 8'haa;
    localparam logic [7:0] TYPE_PRESS   = 8'h01;
    localparam logic [7:0] TYPE_RELEASE = 8'h03;
    localparam logic [7:0] BYTE_POLL    = 8'hfa;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] now_ms;
    } rx_word_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic        is_touched;
        logic        is_released;
        logic [15:0] frame_x;
        logic [15:0] frame_y;
        logic [15:0] chosen_x;
        logic [15:0] chosen_y;
        logic [31:0] event_time;
    } result_t;

endpackage

### hdl/trf_in_reg.sv
// ----------------------------------------------------------------------------
// Touch report input register
// Holds one received word until the parser takes it.
// ----------------------------------------------------------------------------
module trf_in_reg import trf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic [31:0] s_now_ms,
    input  logic        take,
    output logic        word_valid,
    output rx_word_t    word
);

    logic     valid_reg;
    logic     valid_next;
    rx_word_t word_reg;

    assign s_ready    = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg.rx_byte <= s_rx_byte;
            word_reg.now_ms  <= s_now_ms;
        end
    end

endmodule

### hdl/trf_core.sv
// ----------------------------------------------------------------------------
// Touch report parser core
// Frame state machine, stored coordinates and times, and the result of
// each word.
// ----------------------------------------------------------------------------
module trf_core import trf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_write,
    input  logic [2:0] cfg_mode,
    input  logic       word_valid,
    input  rx_word_t   word,
    input  logic       out_free,
    output logic       take,
    output logic       res_valid,
    output result_t    result
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  mode_reg;
    logic [7:0]  frame_type_reg, frame_type_next;
    logic [15:0] x_hold_reg, x_hold_next;
    logic [15:0] y_hold_reg, y_hold_next;
    logic [15:0] press_x_reg, press_x_next;
    logic [15:0] press_y_reg, press_y_next;
    logic [31:0] press_time_reg, press_time_next;
    logic [15:0] release_x_reg, release_x_next;
    logic [15:0] release_y_reg, release_y_next;
    logic [31:0] release_time_reg, release_time_next;
    logic [15:0] poll_x_reg, poll_x_next;
    logic [15:0] poll_y_reg, poll_y_next;
    logic        touched_reg, touched_next;
    logic        released_reg, released_next;
    logic        emit;
    event_kind_t kind;
    logic [15:0] frame_x, frame_y;
    logic [31:0] event_time;
    logic [15:0] chosen_x, chosen_y;
    logic        polled;
    logic [7:0]  b;
    logic [7:0]  end_byte;
    logic [2:0]  mode_clean;

    assign take   = word_valid && out_free;
    assign polled = (mode_reg == MODE_POLLED);
    assign b      = word.rx_byte;
    assign mode_clean = (cfg_mode >= MODE_PRESS && cfg_mode <= MODE_PRESS_OR_RL) ?
                        cfg_mode : MODE_POLLED;

    always_comb begin
        unique case (phase_reg)
            PH_E1:   end_byte = BYTE_END1;
            PH_E2:   end_byte = BYTE_END2;
            default: end_byte = BYTE_END3;
        endcase
    end

    always_comb begin
        unique case (phase_reg)
            PH_HUNT: begin
                if (polled) begin
                    phase_next = (b == BYTE_POLL) ? PH_XH : PH_HUNT;
                end else begin
                    phase_next = (b == BYTE_START) ? PH_TYPE : PH_HUNT;
                end
            end
            PH_TYPE: phase_next = PH_XH;
            PH_XH:   phase_next = PH_XL;
            PH_XL:   phase_next = PH_YH;
            PH_YH:   phase_next = PH_YL;
            PH_YL:   phase_next = polled ? PH_HUNT : PH_E1;
            PH_E1:   phase_next = (b == end_byte) ? PH_E2 : PH_HUNT;
            PH_E2:   phase_next = (b == end_byte) ? PH_E3 : PH_HUNT;
            PH_E3:   phase_next = (b == end_byte) ? PH_E4 : PH_HUNT;
            default: phase_next = PH_HUNT;
        endcase
    end

    always_comb begin
        frame_type_next   = frame_type_reg;
        x_hold_next       = x_hold_reg;
        y_hold_next       = y_hold_reg;
        press_x_next      = press_x_reg;
        press_y_next      = press_y_reg;
        press_time_next   = press_time_reg;
        release_x_next    = release_x_reg;
        release_y_next    = release_y_reg;
        release_time_next = release_time_reg;
        poll_x_next       = poll_x_reg;
        poll_y_next       = poll_y_reg;
        touched_next      = touched_reg;
        released_next     = released_reg;
        emit              = 1'b0;
        kind              = EV_POLL_NONE;
        frame_x           = 16'd0;
        frame_y           = 16'd0;
        event_time        = 32'd0;
        unique case (phase_reg)
            PH_HUNT: begin
                if (polled && b != BYTE_POLL) begin
                    touched_next = 1'b0;
                    emit         = 1'b1;
                end
            end
            PH_TYPE: frame_type_next = b;
            PH_XH:   x_hold_next = {b, 8'h00};
            PH_XL:   x_hold_next = {x_hold_reg[15:8], b};
            PH_YH:   y_hold_next = {b, 8'h00};
            PH_YL: begin
                y_hold_next = {y_hold_reg[15:8], b};
                if (polled) begin
                    poll_x_next  = x_hold_reg;
                    poll_y_next  = {y_hold_reg[15:8], b};
                    touched_next = 1'b1;
                    emit         = 1'b1;
                    kind         = EV_POLL_TOUCH;
                    frame_x      = x_hold_reg;
                    frame_y      = {y_hold_reg[15:8], b};
                end
            end
            PH_E1, PH_E2, PH_E3: begin
                if (b != end_byte) begin
                    touched_next  = 1'b0;
                    released_next = 1'b0;
                end
            end
            PH_E4: begin
                touched_next  = 1'b0;
                released_next = 1'b0;
                if (b == BYTE_END4) begin
                    priority if (frame_type_reg == TYPE_PRESS) begin
                        press_x_next    = x_hold_reg;
                        press_y_next    = y_hold_reg;
                        press_time_next = word.now_ms;
                        touched_next    = 1'b1;
                        emit            = 1'b1;
                        kind            = EV_PRESS;
                        frame_x         = x_hold_reg;
                        frame_y         = y_hold_reg;
                        event_time      = word.now_ms;
                    end else if (frame_type_reg == TYPE_RELEASE) begin
                        release_x_next    = x_hold_reg;
                        release_y_next    = y_hold_reg;
                        release_time_next = word.now_ms;
                        released_next     = 1'b1;
                        emit              = 1'b1;
                        kind              = EV_RELEASE;
                        frame_x           = x_hold_reg;
                        frame_y           = y_hold_reg;
                        event_time        = word.now_ms;
                    end else begin
                        emit = 1'b0;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // The chosen coordinates reflect the stored values after this word.
    always_comb begin
        priority if (mode_reg == MODE_PRESS || mode_reg == MODE_PERIODIC) begin
            chosen_x = press_x_next;
            chosen_y = press_y_next;
        end else if (mode_reg == MODE_RELEASE) begin
            chosen_x = release_x_next;
            chosen_y = release_y_next;
        end else if (mode_reg == MODE_PRESS_OR_RL) begin
            if (press_time_next > release_time_next) begin
                chosen_x = press_x_next;
                chosen_y = press_y_next;
            end else begin
                chosen_x = release_x_next;
                chosen_y = release_y_next;
            end
        end else begin
            chosen_x = poll_x_next;
            chosen_y = poll_y_next;
        end
    end

    assign res_valid          = take && emit;
    assign result.event_kind  = kind;
    assign result.is_touched  = touched_next;
    assign result.is_released = released_next;
    assign result.frame_x     = frame_x;
    assign result.frame_y     = frame_y;
    assign result.chosen_x    = chosen_x;
    assign result.chosen_y    = chosen_y;
    assign result.event_time  = event_time;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            mode_reg         <= MODE_POLLED;
            frame_type_reg   <= 8'd0;
            x_hold_reg       <= 16'd0;
            y_hold_reg       <= 16'd0;
            press_x_reg      <= 16'd0;
            press_y_reg      <= 16'd0;
            press_time_reg   <= 32'd0;
            release_x_reg    <= 16'd0;
            release_y_reg    <= 16'd0;
            release_time_reg <= 32'd0;
            poll_x_reg       <= 16'd0;
            poll_y_reg       <= 16'd0;
            touched_reg      <= 1'b0;
            released_reg     <= 1'b0;
        end else if (cfg_write) begin
            mode_reg  <= mode_clean;
            phase_reg <= PH_HUNT;
        end else if (take) begin
            phase_reg        <= phase_next;
            frame_type_reg   <= frame_type_next;
            x_hold_reg       <= x_hold_next;
            y_hold_reg       <= y_hold_next;
            press_x_reg      <= press_x_next;
            press_y_reg      <= press_y_next;
            press_time_reg   <= press_time_next;
            release_x_reg    <= release_x_next;
            release_y_reg    <= release_y_next;
            release_time_reg <= release_time_next;
            poll_x_reg       <= poll_x_next;
            poll_y_reg       <= poll_y_next;
            touched_reg      <= touched_next;
            released_reg     <= released_next;
        end
    end

endmodule

### hdl/trf_out_reg.sv
// ----------------------------------------------------------------------------
// Touch report result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module trf_out_reg import trf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    take,
    input  logic    res_valid,
    input  result_t result,
    output logic    out_free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        if (out_free) begin
            valid_next = take && res_valid;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && take && res_valid) begin
            result_reg <= result;
        end
    end

endmodule

### hdl/touch_report_frame_parser.sv
// ----------------------------------------------------------------------------
// Touch report frame parser
// Parses report frames from a touch display link, one byte word per cycle when not stalled,
// and returns a result word for each press, release or polled report.
//
// Channel   Direction  Ports                            Word
// s_        in         s_valid s_ready                  rx_byte, now_ms
// m_        out        m_valid m_ready                  one report result
// cfg_      in         cfg_valid cfg_ready              touch_mode
//
// Each byte word waits in the input register while the parser works on it,
// and its result word, if any, is then held in the result register; one
// word can be accepted every cycle while the result register is free. A
// stalled result word stays in the result register and stalls the parser and
// then the input register. Reset is synchronous and active low; it selects
// polled mode and clears all stored coordinates.
// ----------------------------------------------------------------------------
module touch_report_frame_parser import trf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_touch_mode,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic [31:0] s_now_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic        m_is_touched,
    output logic        m_is_released,
    output logic [15:0] m_frame_x,
    output logic [15:0] m_frame_y,
    output logic [15:0] m_chosen_x,
    output logic [15:0] m_chosen_y,
    output logic [31:0] m_event_time
);

    logic     take;
    logic     word_valid;
    rx_word_t word;
    logic     out_free;
    logic     res_valid;
    result_t  result;
    result_t  m_result;

    assign cfg_ready = 1'b1;

    trf_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .s_now_ms   (s_now_ms),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    trf_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_mode   (cfg_touch_mode),
        .word_valid (word_valid),
        .word       (word),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .result     (result)
    );

    trf_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .res_valid (res_valid),
        .result    (result),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

    assign m_event_kind  = m_result.event_kind;
    assign m_is_touched  = m_result.is_touched;
    assign m_is_released = m_result.is_released;
    assign m_frame_x     = m_result.frame_x;
    assign m_frame_y     = m_result.frame_y;
    assign m_chosen_x    = m_result.chosen_x;
    assign m_chosen_y    = m_result.chosen_y;
    assign m_event_time  = m_result.event_time;

endmodule
